[design/sbme_pkg.sv]
// Shared types, codes and constants of the STUN binding message engine.
package sbme_pkg;

  // Default sizes
  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int USER_MAX_DEF      = 16;
  localparam int PACKET_MAX_DEF    = 1024;

  localparam int HEADER_BYTES = 20;
  localparam logic [15:0] AGE_LIMIT_RESET = 16'd300;

  // Input item functions
  localparam logic [1:0] FUNC_BYTE   = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [1:0] FUNC_REMOVE = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_BYTE    = 3'd0;
  localparam logic [2:0] KIND_VERDICT = 3'd1;
  localparam logic [2:0] KIND_LOOKUP  = 3'd2;
  localparam logic [2:0] KIND_INSERT  = 3'd3;
  localparam logic [2:0] KIND_REMOVE  = 3'd4;

  // Packet verdicts
  localparam logic [1:0] VERDICT_IGNORED  = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
  localparam logic [1:0] VERDICT_RUNT     = 2'd2;

  // Message and attribute types
  localparam logic [15:0] MSG_BIND_REQ  = 16'h0001;
  localparam logic [15:0] MSG_BIND_RESP = 16'h0101;
  localparam logic [15:0] ATTR_MAPPED   = 16'h0001;
  localparam logic [15:0] ATTR_USER     = 16'h0006;
  localparam logic [7:0]  FAMILY_IPV4   = 8'h01;
  localparam logic [7:0]  MAPPED_LEN    = 8'h08;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_AHDR,
    PH_VALUE,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_LOOKUP,
    CMD_REMOVE,
    CMD_VERDICT,
    CMD_BIND_REQ,
    CMD_BIND_RESP
  } cmd_op_e;

  // One classified job handed from front to back
  typedef struct packed {
    cmd_op_e     op;
    logic [1:0]  verdict;
    logic [63:0] id_hi;
    logic [63:0] id_lo;
    logic [31:0] now;
    logic [31:0] ip;
    logic [15:0] port;
    logic [47:0] mapped;
    logic        user_present;
    logic [4:0]  user_len;
  } cmd_t;

endpackage

[design/sbme_front.sv]
// Front end: accepts items, parses packets byte by byte and classifies jobs.
module sbme_front #(
  parameter int USER_MAX   = sbme_pkg::USER_MAX_DEF,
  parameter int PACKET_MAX = sbme_pkg::PACKET_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            func_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  rx_last_i,
  input  logic [31:0]           src_ip_i,
  input  logic [15:0]           src_port_i,
  input  logic [63:0]           trans_id_high_i,
  input  logic [63:0]           trans_id_low_i,
  input  logic [31:0]           now_seconds_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output sbme_pkg::cmd_t        cmd_o,
  output logic [USER_MAX*8-1:0] user_o
);
  import sbme_pkg::*;

  localparam int OW  = $clog2(PACKET_MAX + 1);
  localparam int UIW = $clog2(USER_MAX);

  phase_e          phase_q, phase_d;
  logic [OW-1:0]   off_q, off_d;
  logic [7:0]      hdr_q [HEADER_BYTES];
  logic [7:0]      hdr_d [HEADER_BYTES];
  logic [15:0]     rem_q, rem_d;
  logic [15:0]     atype_q, atype_d;
  logic [15:0]     alen_q, alen_d;
  logic [15:0]     apos_q, apos_d;
  logic [7:0]      user_q [USER_MAX];
  logic [7:0]      user_d [USER_MAX];
  logic [4:0]      ulen_q, ulen_d;
  logic            upres_q, upres_d;
  logic            uend_q, uend_d;
  logic [47:0]     seen_q, seen_d;
  logic [31:0]     ip_q, ip_d;
  logic [15:0]     port_q, port_d;
  logic            accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Parse step and job classification
  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    hdr_d   = hdr_q;
    rem_d   = rem_q;
    atype_d = atype_q;
    alen_d  = alen_q;
    apos_d  = apos_q;
    user_d  = user_q;
    ulen_d  = ulen_q;
    upres_d = upres_q;
    uend_d  = uend_q;
    seen_d  = seen_q;
    ip_d    = ip_q;
    port_d  = port_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    cmd_o.op = CMD_VERDICT;
    if (accept && func_i == FUNC_BYTE) begin
      // first byte of a packet starts clean
      if (off_q == '0) begin
        ip_d    = src_ip_i;
        port_d  = src_port_i;
        upres_d = 1'b0;
        uend_d  = 1'b0;
        ulen_d  = 5'd0;
        seen_d  = '0;
        rem_d   = 16'd0;
        apos_d  = 16'd0;
        phase_d = PH_HEADER;
      end
      if (off_q < OW'(PACKET_MAX)) begin
        case (phase_d)
          PH_HEADER: begin
            if (off_q < OW'(HEADER_BYTES)) hdr_d[off_q[4:0]] = rx_byte_i;
            if (off_q == OW'(HEADER_BYTES - 1)) begin
              rem_d   = {hdr_d[2], hdr_d[3]};
              apos_d  = 16'd0;
              phase_d = (rem_d == 16'd0) ? PH_DONE : PH_AHDR;
            end
          end
          PH_AHDR: begin
            if (apos_d == 16'd0 && rem_d < 16'd4) begin
              phase_d = PH_ERROR;
            end else begin
              case (apos_d[1:0])
                2'd0:    atype_d[15:8] = rx_byte_i;
                2'd1:    atype_d[7:0]  = rx_byte_i;
                2'd2:    alen_d[15:8]  = rx_byte_i;
                default: alen_d[7:0]   = rx_byte_i;
              endcase
              apos_d = apos_d + 16'd1;
              rem_d  = rem_d - 16'd1;
              if (apos_d == 16'd4) begin
                if (alen_d > rem_d) begin
                  phase_d = PH_ERROR;
                end else begin
                  if (atype_d == ATTR_USER) begin
                    upres_d = 1'b1;
                    ulen_d  = 5'd0;
                    uend_d  = 1'b0;
                  end else if (atype_d == ATTR_MAPPED) begin
                    seen_d = '0;
                  end
                  apos_d = 16'd0;
                  if (alen_d == 16'd0) begin
                    phase_d = (rem_d == 16'd0) ? PH_DONE : PH_AHDR;
                  end else begin
                    phase_d = PH_VALUE;
                  end
                end
              end
            end
          end
          PH_VALUE: begin
            if (atype_d == ATTR_USER && !uend_d) begin
              // username stops at the first zero byte
              if (rx_byte_i == 8'd0) begin
                uend_d = 1'b1;
              end else if (ulen_d < 5'(USER_MAX)) begin
                user_d[ulen_d[UIW-1:0]] = rx_byte_i;
                ulen_d = ulen_d + 5'd1;
              end
            end else if (atype_d == ATTR_MAPPED && apos_d >= 16'd2 && apos_d < 16'd8) begin
              seen_d[8 * (3'd7 - apos_d[2:0]) +: 8] = rx_byte_i;
            end
            apos_d = apos_d + 16'd1;
            rem_d  = rem_d - 16'd1;
            if (apos_d >= alen_d) begin
              apos_d  = 16'd0;
              phase_d = (rem_d == 16'd0) ? PH_DONE : PH_AHDR;
            end
          end
          default: ;
        endcase
        off_d = off_q + OW'(1);
      end
      // final byte: classify the packet
      if (rx_last_i) begin
        push_o = 1'b1;
        for (int i = 0; i < 8; i++) begin
          cmd_o.id_hi[63 - 8 * i -: 8] = hdr_d[4 + i];
          cmd_o.id_lo[63 - 8 * i -: 8] = hdr_d[12 + i];
        end
        cmd_o.ip           = ip_d;
        cmd_o.port         = port_d;
        cmd_o.mapped       = seen_d;
        cmd_o.user_present = upres_d;
        cmd_o.user_len     = ulen_d;
        if (off_d < OW'(HEADER_BYTES)) begin
          cmd_o.verdict = VERDICT_RUNT;
        end else if (phase_d == PH_ERROR || phase_d == PH_VALUE ||
                     (phase_d == PH_AHDR && apos_d != 16'd0)) begin
          cmd_o.verdict = VERDICT_IGNORED;
        end else if ({hdr_d[0], hdr_d[1]} == MSG_BIND_REQ) begin
          cmd_o.op = CMD_BIND_REQ;
        end else if ({hdr_d[0], hdr_d[1]} == MSG_BIND_RESP) begin
          cmd_o.op = CMD_BIND_RESP;
        end else begin
          cmd_o.verdict = VERDICT_IGNORED;
        end
        phase_d = PH_HEADER;
        off_d   = '0;
        rem_d   = 16'd0;
        apos_d  = 16'd0;
      end
    end else if (accept) begin
      // table items go straight to the back end
      push_o      = 1'b1;
      cmd_o.id_hi = trans_id_high_i;
      cmd_o.id_lo = trans_id_low_i;
      cmd_o.now   = now_seconds_i;
      case (func_i)
        FUNC_INSERT: cmd_o.op = CMD_INSERT;
        FUNC_LOOKUP: cmd_o.op = CMD_LOOKUP;
        default:     cmd_o.op = CMD_REMOVE;
      endcase
    end
  end

  // Username bytes travel beside the job
  always_comb begin
    for (int i = 0; i < USER_MAX; i++) begin
      user_o[8 * i +: 8] = user_d[i];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      off_q   <= '0;
      rem_q   <= 16'd0;
      apos_q  <= 16'd0;
      ulen_q  <= 5'd0;
      upres_q <= 1'b0;
      uend_q  <= 1'b0;
      seen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      off_q   <= off_d;
      rem_q   <= rem_d;
      apos_q  <= apos_d;
      ulen_q  <= ulen_d;
      upres_q <= upres_d;
      uend_q  <= uend_d;
      seen_q  <= seen_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    hdr_q   <= hdr_d;
    user_q  <= user_d;
    atype_q <= atype_d;
    alen_q  <= alen_d;
    ip_q    <= ip_d;
    port_q  <= port_d;
  end

endmodule

[design/sbme_queue.sv]
// Two-entry job queue between front and back end.
module sbme_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

[design/sbme_back.sv]
// Back end: pending table, binding response emitter and result register.
module sbme_back #(
  parameter int TABLE_ENTRIES = sbme_pkg::TABLE_ENTRIES_DEF,
  parameter int USER_MAX      = sbme_pkg::USER_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  sbme_pkg::cmd_t        cmd_i,
  input  logic [USER_MAX*8-1:0] user_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            out_kind_o,
  output logic [7:0]            tx_byte_o,
  output logic                  last_of_run_o,
  output logic [1:0]            verdict_o,
  output logic                  found_o,
  output logic [31:0]           mapped_ip_o,
  output logic [15:0]           mapped_port_o
);
  import sbme_pkg::*;

  localparam int UIW = $clog2(USER_MAX);

  logic [15:0] age_q;
  logic [5:0]  idx_q, idx_d;
  logic        ev_q [TABLE_ENTRIES];
  logic        ev_d [TABLE_ENTRIES];
  logic        ea_q [TABLE_ENTRIES];
  logic        ea_d [TABLE_ENTRIES];
  logic [63:0] idh_q [TABLE_ENTRIES];
  logic [63:0] idh_d [TABLE_ENTRIES];
  logic [63:0] idl_q [TABLE_ENTRIES];
  logic [63:0] idl_d [TABLE_ENTRIES];
  logic [47:0] emap_q [TABLE_ENTRIES];
  logic [47:0] emap_d [TABLE_ENTRIES];
  logic [31:0] etime_q [TABLE_ENTRIES];
  logic [31:0] etime_d [TABLE_ENTRIES];

  logic        ov_q, ov_d;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [1:0]  verd_q, verd_d;
  logic        found_q, found_d;
  logic [47:0] map_q, map_d;

  logic        go;
  logic [15:0] mlen;
  logic [5:0]  r2, ui, m, ulen6;
  logic        done;

  assign out_valid_o   = ov_q;
  assign out_kind_o    = kind_q;
  assign tx_byte_o     = byte_q;
  assign last_of_run_o = last_q;
  assign verdict_o     = verd_q;
  assign found_o       = found_q;
  assign mapped_ip_o   = map_q[31:0];
  assign mapped_port_o = map_q[47:32];

  assign go    = (!ov_q || !out_stall_i) && !empty_i;
  assign ulen6 = {1'b0, cmd_i.user_len};
  assign mlen  = cmd_i.user_present ? 16'd16 + {11'd0, cmd_i.user_len} : 16'd12;
  assign r2    = idx_q - 6'd20;
  assign ui    = r2 - 6'd4;
  assign m     = cmd_i.user_present ? (r2 - 6'd4 - ulen6) : r2;

  // Result sequencing and table update
  always_comb begin
    logic hit;
    hit     = 1'b0;
    ev_d    = ev_q;
    ea_d    = ea_q;
    idh_d   = idh_q;
    idl_d   = idl_q;
    emap_d  = emap_q;
    etime_d = etime_q;
    idx_d   = idx_q;
    ov_d    = ov_q;
    kind_d  = kind_q;
    byte_d  = byte_q;
    last_d  = last_q;
    verd_d  = verd_q;
    found_d = found_q;
    map_d   = map_q;
    pop_o   = 1'b0;
    done    = 1'b1;
    if (!ov_q || !out_stall_i) ov_d = 1'b0;
    if (go) begin
      ov_d    = 1'b1;
      kind_d  = KIND_VERDICT;
      byte_d  = 8'd0;
      verd_d  = VERDICT_IGNORED;
      found_d = 1'b0;
      map_d   = '0;
      case (cmd_i.op)
        CMD_BIND_REQ: begin
          done   = 1'b0;
          kind_d = KIND_BYTE;
          if (idx_q < 6'd4) begin
            case (idx_q[1:0])
              2'd0:    byte_d = 8'h01;
              2'd1:    byte_d = 8'h01;
              2'd2:    byte_d = mlen[15:8];
              default: byte_d = mlen[7:0];
            endcase
          end else if (idx_q < 6'd12) begin
            byte_d = cmd_i.id_hi[63 - 8 * (idx_q - 6'd4) -: 8];
          end else if (idx_q < 6'd20) begin
            byte_d = cmd_i.id_lo[63 - 8 * (idx_q - 6'd12) -: 8];
          end else if (cmd_i.user_present && r2 < 6'd4) begin
            case (r2[1:0])
              2'd0:    byte_d = 8'h00;
              2'd1:    byte_d = ATTR_USER[7:0];
              2'd2:    byte_d = 8'h00;
              default: byte_d = {3'd0, cmd_i.user_len};
            endcase
          end else if (cmd_i.user_present && ui < ulen6) begin
            byte_d = user_i[8 * ui[UIW-1:0] +: 8];
          end else if (m < 6'd12) begin
            case (m[3:0])
              4'd0:    byte_d = 8'h00;
              4'd1:    byte_d = ATTR_MAPPED[7:0];
              4'd2:    byte_d = 8'h00;
              4'd3:    byte_d = MAPPED_LEN;
              4'd4:    byte_d = 8'h00;
              4'd5:    byte_d = FAMILY_IPV4;
              4'd6:    byte_d = cmd_i.port[15:8];
              4'd7:    byte_d = cmd_i.port[7:0];
              4'd8:    byte_d = cmd_i.ip[31:24];
              4'd9:    byte_d = cmd_i.ip[23:16];
              4'd10:   byte_d = cmd_i.ip[15:8];
              default: byte_d = cmd_i.ip[7:0];
            endcase
          end else begin
            kind_d = KIND_VERDICT;
            verd_d = VERDICT_ACCEPTED;
            done   = 1'b1;
          end
        end
        CMD_BIND_RESP: begin
          verd_d = VERDICT_ACCEPTED;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (ev_q[i] && !ea_q[i] && idh_q[i] == cmd_i.id_hi && idl_q[i] == cmd_i.id_lo) begin
              ea_d[i]   = 1'b1;
              emap_d[i] = cmd_i.mapped;
            end
          end
        end
        CMD_INSERT: begin
          kind_d = KIND_INSERT;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!ev_q[i] && !hit) begin
              hit        = 1'b1;
              ev_d[i]    = 1'b1;
              ea_d[i]    = 1'b0;
              idh_d[i]   = cmd_i.id_hi;
              idl_d[i]   = cmd_i.id_lo;
              emap_d[i]  = '0;
              etime_d[i] = cmd_i.now;
            end
          end
          found_d = hit;
        end
        CMD_LOOKUP: begin
          kind_d = KIND_LOOKUP;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (ev_q[i] && ea_q[i] && idh_q[i] == cmd_i.id_hi && idl_q[i] == cmd_i.id_lo
                && !hit) begin
              hit   = 1'b1;
              map_d = emap_q[i];
            end
          end
          found_d = hit;
        end
        CMD_REMOVE: begin
          kind_d = KIND_REMOVE;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (ev_q[i] && ea_q[i] && idh_q[i] == cmd_i.id_hi && idl_q[i] == cmd_i.id_lo) begin
              ev_d[i] = 1'b0;
              ea_d[i] = 1'b0;
              hit     = 1'b1;
            end else if (ev_q[i] &&
                         ({1'b0, etime_q[i]} + {17'd0, age_q}) < {1'b0, cmd_i.now}) begin
              // aged out
              ev_d[i] = 1'b0;
              ea_d[i] = 1'b0;
            end
          end
          found_d = hit;
        end
        default: verd_d = cmd_i.verdict;
      endcase
      last_d = done;
      if (done) begin
        pop_o = 1'b1;
        idx_d = 6'd0;
      end else begin
        idx_d = idx_q + 6'd1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= AGE_LIMIT_RESET;
      idx_q <= 6'd0;
      ov_q  <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ev_q[i] <= 1'b0;
        ea_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) age_q <= cfg_wdata_i;
      idx_q <= idx_d;
      ov_q  <= ov_d;
      ev_q  <= ev_d;
      ea_q  <= ea_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    idh_q   <= idh_d;
    idl_q   <= idl_d;
    emap_q  <= emap_d;
    etime_q <= etime_d;
    kind_q  <= kind_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
    verd_q  <= verd_d;
    found_q <= found_d;
    map_q   <= map_d;
  end

endmodule

[design/stun_binding_message_engine.sv]
// Input: a packet byte is taken every cycle unless the input is stalled; results of a
// final byte or table item pass the job queue and then the output register.
// Throughput: a binding request gives 33 to 53 result beats, one per cycle from the back
// end unless stalled; other jobs give one beat. A full two-entry job queue stalls input.
// Reset: asynchronous, clears parse state, queue, output valid and all table entries.
module stun_binding_message_engine #(
  parameter int TABLE_ENTRIES = sbme_pkg::TABLE_ENTRIES_DEF,
  parameter int USER_MAX      = sbme_pkg::USER_MAX_DEF,
  parameter int PACKET_MAX    = sbme_pkg::PACKET_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic [31:0] src_ip_i,
  input  logic [15:0] src_port_i,
  input  logic [63:0] trans_id_high_i,
  input  logic [63:0] trans_id_low_i,
  input  logic [31:0] now_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_of_run_o,
  output logic [1:0]  verdict_o,
  output logic        found_o,
  output logic [31:0] mapped_ip_o,
  output logic [15:0] mapped_port_o
);
  import sbme_pkg::*;

  localparam int QW = $bits(cmd_t) + USER_MAX * 8;

  logic                  push, pop, full, empty;
  cmd_t                  f_cmd, b_cmd;
  logic [USER_MAX*8-1:0] f_user, b_user;

  sbme_front #(
    .USER_MAX   (USER_MAX),
    .PACKET_MAX (PACKET_MAX)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .rx_byte_i       (rx_byte_i),
    .rx_last_i       (rx_last_i),
    .src_ip_i        (src_ip_i),
    .src_port_i      (src_port_i),
    .trans_id_high_i (trans_id_high_i),
    .trans_id_low_i  (trans_id_low_i),
    .now_seconds_i   (now_seconds_i),
    .q_full_i        (full),
    .push_o          (push),
    .cmd_o           (f_cmd),
    .user_o          (f_user)
  );

  sbme_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_user, f_cmd}),
    .pop_i   (pop),
    .data_o  ({b_user, b_cmd}),
    .full_o  (full),
    .empty_o (empty)
  );

  sbme_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .USER_MAX      (USER_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (b_cmd),
    .user_i        (b_user),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .tx_byte_o     (tx_byte_o),
    .last_of_run_o (last_of_run_o),
    .verdict_o     (verdict_o),
    .found_o       (found_o),
    .mapped_ip_o   (mapped_ip_o),
    .mapped_port_o (mapped_port_o)
  );

`ifndef SYNTHESIS
  // response bytes never close a run
  a_byte_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_BYTE |-> !last_of_run_o)
    else $error("response byte marked last");

  // a verdict beat always closes its run
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_VERDICT |-> last_of_run_o)
    else $error("verdict not last");

  // found only on table answers
  a_found_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> out_kind_o == KIND_LOOKUP || out_kind_o == KIND_INSERT ||
    out_kind_o == KIND_REMOVE)
    else $error("found on wrong kind");

  // no pop from an empty queue
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("pop on empty queue");
`endif

endmodule

[sim/stun_binding_message_engine_test.sv]
// Self-checking testbench for the STUN binding message engine.
module stun_binding_message_engine_test;
  import sbme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int N_IDS          = 6;

  // One result beat, fields in port order
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx;
    logic        last;
    logic [1:0]  verdict;
    logic        found;
    logic [31:0] ip;
    logic [15:0] port;
  } beat_t;

  typedef enum {ACT_PKT, ACT_INSERT, ACT_LOOKUP, ACT_REMOVE, ACT_CFG} act_e;
  typedef enum {
    SH_NONE, SH_RUNT, SH_REQ_PLAIN, SH_REQ_USER, SH_REQ_EMPTY_USER, SH_RESP_MAPPED,
    SH_RESP_SHORT, SH_BAD_VALUE, SH_RUNT_ATTR, SH_CLAMP, SH_CUTOFF, SH_TRAILING,
    SH_UNKNOWN, SH_OVERSIZE
  } shape_e;

  typedef struct {
    act_e        act;
    shape_e      shape;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] now;
    int          rep;
    bit          typed;
    beat_t       want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = FUNC_BYTE;
  logic [7:0]  rx_byte_i = '0;
  logic        rx_last_i = 1'b0;
  logic [31:0] src_ip_i = '0;
  logic [15:0] src_port_i = '0;
  logic [63:0] trans_id_high_i = '0;
  logic [63:0] trans_id_low_i = '0;
  logic [31:0] now_seconds_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  out_kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_of_run_o;
  logic [1:0]  verdict_o;
  logic        found_o;
  logic [31:0] mapped_ip_o;
  logic [15:0] mapped_port_o;

  stun_binding_message_engine u_top (
    .clk_i(clk), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .func_i(func_i),
    .rx_byte_i(rx_byte_i), .rx_last_i(rx_last_i), .src_ip_i(src_ip_i),
    .src_port_i(src_port_i), .trans_id_high_i(trans_id_high_i),
    .trans_id_low_i(trans_id_low_i), .now_seconds_i(now_seconds_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_kind_o(out_kind_o),
    .tx_byte_o(tx_byte_o), .last_of_run_o(last_of_run_o), .verdict_o(verdict_o),
    .found_o(found_o), .mapped_ip_o(mapped_ip_o), .mapped_port_o(mapped_port_o)
  );

  always #4 clk = ~clk;

  // Engine shadow state
  logic [15:0] age_lim;
  phase_e      phase;
  int          boff;
  logic [7:0]  hdr_buf[HEADER_BYTES];
  int          attr_rem;
  logic [7:0]  user_buf[USER_MAX_DEF];
  int          ulen;
  bit          upres, uend;
  logic [47:0] seen_map;
  logic [15:0] atype, alen;
  int          apos;
  logic [31:0] pkt_ip;
  logic [15:0] pkt_port;
  bit          ent_valid[TABLE_ENTRIES_DEF], ent_ans[TABLE_ENTRIES_DEF];
  logic [63:0] ent_hi[TABLE_ENTRIES_DEF], ent_lo[TABLE_ENTRIES_DEF];
  logic [47:0] ent_map[TABLE_ENTRIES_DEF];
  logic [31:0] ent_time[TABLE_ENTRIES_DEF];

  beat_t       run_beats[$];
  beat_t       expected_beats[$];
  logic [7:0]  pkt_bytes[$];

  int  items_in, beats_out, packets_sent, mismatches, strays;
  bit  calm, hold_go, hold_done;
  int  hold_left, quiet_cnt;
  logic [63:0] ids_hi[N_IDS], ids_lo[N_IDS];
  logic [31:0] clock_s;

  function automatic beat_t mk(logic [2:0] kind, logic [1:0] v, logic f);
    beat_t b;
    b = '0;
    b.kind = kind;
    b.verdict = v;
    b.found = f;
    b.last = 1'b1;
    return b;
  endfunction

  function automatic void add_beat(logic [2:0] kind, logic [7:0] tx, logic [1:0] v,
                                   logic f, logic [47:0] m);
    beat_t b;
    b = '{kind, tx, 1'b0, v, f, m[31:0], m[47:32]};
    run_beats.push_back(b);
  endfunction

  function automatic void end_attr();
    apos = 0;
    phase = (attr_rem == 0) ? PH_DONE : PH_AHDR;
  endfunction

  // Parse one packet byte
  function automatic void parse_byte(logic [7:0] b);
    int sh;
    case (phase)
      PH_HEADER: begin
        if (boff < HEADER_BYTES) hdr_buf[boff] = b;
        if (boff == HEADER_BYTES - 1) begin
          attr_rem = {hdr_buf[2], hdr_buf[3]};
          apos = 0;
          phase = (attr_rem == 0) ? PH_DONE : PH_AHDR;
        end
      end
      PH_AHDR: begin
        if (apos == 0 && attr_rem < 4) begin
          phase = PH_ERROR;
        end else begin
          case (apos)
            0: atype[15:8] = b;
            1: atype[7:0] = b;
            2: alen[15:8] = b;
            default: alen[7:0] = b;
          endcase
          apos++;
          attr_rem--;
          if (apos == 4) begin
            if (alen > attr_rem) begin
              phase = PH_ERROR;
            end else begin
              if (atype == ATTR_USER) begin
                upres = 1;
                ulen = 0;
                uend = 0;
              end else if (atype == ATTR_MAPPED) begin
                seen_map = '0;
              end
              if (alen == 0) end_attr();
              else begin
                apos = 0;
                phase = PH_VALUE;
              end
            end
          end
        end
      end
      PH_VALUE: begin
        if (atype == ATTR_USER && !uend) begin
          if (b == 0) uend = 1;
          else if (ulen < USER_MAX_DEF) user_buf[ulen++] = b;
        end else if (atype == ATTR_MAPPED && apos >= 2 && apos < 8) begin
          sh = (apos < 4) ? 32 + 8 * (3 - apos) : 8 * (7 - apos);
          seen_map |= 48'(b) << sh;
        end
        apos++;
        attr_rem--;
        if (apos >= alen) end_attr();
      end
      default: ;
    endcase
  endfunction

  // Verdict and, for a binding request, the response bytes
  function automatic void close_packet();
    logic [1:0]  v;
    logic [15:0] mlen, mtype;
    logic [63:0] id_h, id_l;
    v = VERDICT_IGNORED;
    if (boff < HEADER_BYTES) begin
      v = VERDICT_RUNT;
    end else if (!(phase == PH_ERROR || phase == PH_VALUE ||
                   (phase == PH_AHDR && apos != 0))) begin
      mtype = {hdr_buf[0], hdr_buf[1]};
      if (mtype == MSG_BIND_REQ) begin
        mlen = 16'(12 + (upres ? 4 + ulen : 0));
        add_beat(KIND_BYTE, MSG_BIND_RESP[15:8], 0, 0, 0);
        add_beat(KIND_BYTE, MSG_BIND_RESP[7:0], 0, 0, 0);
        add_beat(KIND_BYTE, mlen[15:8], 0, 0, 0);
        add_beat(KIND_BYTE, mlen[7:0], 0, 0, 0);
        for (int i = 4; i < HEADER_BYTES; i++) add_beat(KIND_BYTE, hdr_buf[i], 0, 0, 0);
        if (upres) begin
          add_beat(KIND_BYTE, ATTR_USER[15:8], 0, 0, 0);
          add_beat(KIND_BYTE, ATTR_USER[7:0], 0, 0, 0);
          add_beat(KIND_BYTE, 8'h00, 0, 0, 0);
          add_beat(KIND_BYTE, 8'(ulen), 0, 0, 0);
          for (int i = 0; i < ulen; i++) add_beat(KIND_BYTE, user_buf[i], 0, 0, 0);
        end
        add_beat(KIND_BYTE, ATTR_MAPPED[15:8], 0, 0, 0);
        add_beat(KIND_BYTE, ATTR_MAPPED[7:0], 0, 0, 0);
        add_beat(KIND_BYTE, 8'h00, 0, 0, 0);
        add_beat(KIND_BYTE, MAPPED_LEN, 0, 0, 0);
        add_beat(KIND_BYTE, 8'h00, 0, 0, 0);
        add_beat(KIND_BYTE, FAMILY_IPV4, 0, 0, 0);
        add_beat(KIND_BYTE, pkt_port[15:8], 0, 0, 0);
        add_beat(KIND_BYTE, pkt_port[7:0], 0, 0, 0);
        for (int i = 3; i >= 0; i--) add_beat(KIND_BYTE, pkt_ip[8*i+:8], 0, 0, 0);
        v = VERDICT_ACCEPTED;
      end else if (mtype == MSG_BIND_RESP) begin
        for (int i = 0; i < 8; i++) begin
          id_h[8*(7-i)+:8] = hdr_buf[4+i];
          id_l[8*(7-i)+:8] = hdr_buf[12+i];
        end
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
          if (ent_valid[i] && !ent_ans[i] && ent_hi[i] == id_h && ent_lo[i] == id_l) begin
            ent_ans[i] = 1;
            ent_map[i] = seen_map;
          end
        v = VERDICT_ACCEPTED;
      end
    end
    add_beat(KIND_VERDICT, 0, v, 0, 0);
    phase = PH_HEADER;
    boff = 0;
    attr_rem = 0;
    apos = 0;
  endfunction

  // Expected result beats of one accepted input beat, left in run_beats
  function automatic void engine_step(logic [1:0] fn, logic [7:0] b, logic last,
                                      logic [31:0] ip, logic [15:0] port,
                                      logic [63:0] hi, logic [63:0] lo, logic [31:0] now);
    logic        f;
    logic [47:0] m;
    run_beats.delete();
    f = 0;
    m = '0;
    case (fn)
      FUNC_BYTE: begin
        if (boff == 0) begin
          pkt_ip = ip;
          pkt_port = port;
          upres = 0;
          uend = 0;
          ulen = 0;
          seen_map = '0;
          attr_rem = 0;
          apos = 0;
          phase = PH_HEADER;
        end
        if (boff < PACKET_MAX_DEF) begin
          parse_byte(b);
          boff++;
        end
        if (!last) return;
        close_packet();
      end
      FUNC_INSERT: begin
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
          if (!ent_valid[i]) begin
            ent_valid[i] = 1;
            ent_ans[i] = 0;
            ent_hi[i] = hi;
            ent_lo[i] = lo;
            ent_map[i] = '0;
            ent_time[i] = now;
            f = 1;
            break;
          end
        add_beat(KIND_INSERT, 0, 0, f, 0);
      end
      FUNC_LOOKUP: begin
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
          if (ent_valid[i] && ent_ans[i] && ent_hi[i] == hi && ent_lo[i] == lo) begin
            f = 1;
            m = ent_map[i];
            break;
          end
        add_beat(KIND_LOOKUP, 0, 0, f, m);
      end
      default: begin
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
          if (ent_valid[i] && ent_ans[i] && ent_hi[i] == hi && ent_lo[i] == lo) begin
            ent_valid[i] = 0;
            ent_ans[i] = 0;
            f = 1;
          end
        // aging: compare in 33 bits so the sum cannot wrap
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
          if (ent_valid[i] && (33'(ent_time[i]) + 33'(age_lim)) < 33'(now)) begin
            ent_valid[i] = 0;
            ent_ans[i] = 0;
          end
        add_beat(KIND_REMOVE, 0, 0, f, 0);
      end
    endcase
    run_beats[$].last = 1'b1;
  endfunction

  // Drive one input beat; returns at the falling edge after acceptance
  task automatic send_item(logic [1:0] fn, logic [7:0] b, logic last, logic [31:0] ip,
                           logic [15:0] port, logic [63:0] hi, logic [63:0] lo,
                           logic [31:0] now, bit typed = 0, beat_t want = '0);
    if (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    rx_byte_i <= b;
    rx_last_i <= last;
    src_ip_i <= ip;
    src_port_i <= port;
    trans_id_high_i <= hi;
    trans_id_low_i <= lo;
    now_seconds_i <= now;
    do @(posedge clk); while (in_stall_o);
    items_in++;
    engine_step(fn, b, last, ip, port, hi, lo, now);
    if (typed && run_beats.size() == 1) expected_beats.push_back(want);
    else foreach (run_beats[i]) expected_beats.push_back(run_beats[i]);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_table(logic [1:0] fn, logic [63:0] hi, logic [63:0] lo,
                            logic [31:0] now, bit typed = 0, beat_t want = '0);
    send_item(fn, 8'($urandom), 1'($urandom), $urandom, 16'($urandom), hi, lo, now,
              typed, want);
  endtask

  task automatic send_packet(bit typed = 0, beat_t want = '0);
    logic [31:0] ip;
    logic [15:0] port;
    ip = $urandom;
    port = 16'($urandom);
    packets_sent++;
    foreach (pkt_bytes[i])
      send_item(FUNC_BYTE, pkt_bytes[i], i == pkt_bytes.size() - 1,
                i == 0 ? ip : $urandom, i == 0 ? port : 16'($urandom),
                rnd64(), rnd64(), $urandom, typed, want);
  endtask

  task automatic write_age_limit(logic [15:0] val);
    in_valid_i <= 1'b0;
    @(negedge clk);
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 16'($urandom);
    age_lim = val;
  endtask

  // Packet construction
  function automatic void put_hdr(logic [15:0] mtype, logic [15:0] len,
                                  logic [63:0] hi, logic [63:0] lo);
    pkt_bytes.delete();
    pkt_bytes.push_back(mtype[15:8]);
    pkt_bytes.push_back(mtype[7:0]);
    pkt_bytes.push_back(len[15:8]);
    pkt_bytes.push_back(len[7:0]);
    for (int i = 7; i >= 0; i--) pkt_bytes.push_back(hi[8*i+:8]);
    for (int i = 7; i >= 0; i--) pkt_bytes.push_back(lo[8*i+:8]);
  endfunction

  function automatic void put16(logic [15:0] v);
    pkt_bytes.push_back(v[15:8]);
    pkt_bytes.push_back(v[7:0]);
  endfunction

  function automatic void build_shape(shape_e sh, logic [63:0] hi, logic [63:0] lo);
    case (sh)
      SH_RUNT: begin
        pkt_bytes.delete();
        repeat (10) pkt_bytes.push_back(8'($urandom));
      end
      SH_REQ_PLAIN: put_hdr(MSG_BIND_REQ, 0, hi, lo);
      SH_REQ_USER: begin
        // name longer than the store, zero-terminated, one byte after the zero
        put_hdr(MSG_BIND_REQ, 24, hi, lo);
        put16(ATTR_USER);
        put16(20);
        for (int i = 0; i < 18; i++) pkt_bytes.push_back(8'h41 + 8'(i));
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hff);
      end
      SH_REQ_EMPTY_USER: begin
        put_hdr(MSG_BIND_REQ, 12, hi, lo);
        put16(ATTR_USER);
        put16(0);
        put16(16'h8022);
        put16(4);
        repeat (4) pkt_bytes.push_back(8'($urandom));
      end
      SH_RESP_MAPPED: begin
        put_hdr(MSG_BIND_RESP, 12, hi, lo);
        put16(ATTR_MAPPED);
        put16(8);
        put16(16'h0001);
        repeat (6) pkt_bytes.push_back(8'hff);
      end
      SH_RESP_SHORT: begin
        put_hdr(MSG_BIND_RESP, 8, hi, lo);
        put16(ATTR_MAPPED);
        put16(4);
        put16(16'h0001);
        put16(16'h1234);
      end
      SH_BAD_VALUE: begin
        put_hdr(MSG_BIND_REQ, 8, hi, lo);
        put16(ATTR_USER);
        put16(10);
        repeat (4) pkt_bytes.push_back(8'h61);
      end
      SH_RUNT_ATTR: begin
        put_hdr(MSG_BIND_REQ, 6, hi, lo);
        put16(ATTR_USER);
        put16(0);
        put16(16'h0102);
      end
      SH_CLAMP: begin
        put_hdr(MSG_BIND_REQ, 16'hffff, hi, lo);
        put16(ATTR_USER);
        put16(4);
        put16(16'h6162);
        put16(16'h6364);
      end
      SH_CUTOFF: begin
        put_hdr(MSG_BIND_REQ, 16'h0100, hi, lo);
        put16(ATTR_USER);
        put16(200);
        repeat (3) pkt_bytes.push_back(8'h7a);
      end
      SH_TRAILING: begin
        put_hdr(MSG_BIND_REQ, 0, hi, lo);
        repeat (5) pkt_bytes.push_back(8'($urandom));
      end
      SH_UNKNOWN: put_hdr(16'h0111, 0, hi, lo);
      SH_OVERSIZE: begin
        put_hdr(MSG_BIND_REQ, 0, hi, lo);
        repeat (PACKET_MAX_DEF - 14) pkt_bytes.push_back(8'($urandom));
      end
      default: pkt_bytes.delete();
    endcase
  endfunction

  // Well-formed request or response with random attributes
  function automatic void build_random(bit is_req, logic [63:0] hi, logic [63:0] lo);
    logic [7:0] attrs[$];
    int n;
    if ($urandom_range(1)) begin
      n = $urandom_range(0, 20);
      attrs = {attrs, 8'h00, ATTR_USER[7:0], 8'h00, 8'(n)};
      repeat (n) attrs.push_back($urandom_range(9) == 0 ? 8'h00 : 8'($urandom_range(1, 255)));
    end
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(4);
      attrs = {attrs, 8'h80, 8'($urandom), 8'h00, 8'(n)};
      repeat (n) attrs.push_back(8'($urandom));
    end
    if (!is_req || $urandom_range(1)) begin
      n = $urandom_range(3) == 0 ? $urandom_range(0, 7) : 8;
      attrs = {attrs, 8'h00, ATTR_MAPPED[7:0], 8'h00, 8'(n)};
      repeat (n) attrs.push_back(8'($urandom));
    end
    put_hdr(is_req ? MSG_BIND_REQ : MSG_BIND_RESP, 16'(attrs.size()), hi, lo);
    foreach (attrs[i]) pkt_bytes.push_back(attrs[i]);
  endfunction

  // Result checking
  always @(posedge clk) begin
    beat_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_kind_o, tx_byte_o, last_of_run_o, verdict_o, found_o,
              mapped_ip_o, mapped_port_o};
      beats_out++;
      if (expected_beats.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches + strays <= 10)
            $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
        end
      end
    end
  end

  // Receiver stall, with one long hold-off
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !calm && $urandom_range(99) < 31;
    end
  end

  // Watchdog on cycles with no progress
  always @(posedge clk) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cnt = 0;
    else quiet_cnt++;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t    dir_rows[$];
    dir_row_t    row;
    logic [63:0] id_a_hi, id_a_lo, id_b_hi, id_b_lo, id_c_hi, id_c_lo;
    int          base, r, k;
    bit          cfg_mid;

    // engine state after reset
    age_lim = AGE_LIMIT_RESET;
    phase = PH_HEADER;
    boff = 0;
    attr_rem = 0;
    ulen = 0;
    upres = 0;
    uend = 0;
    seen_map = '0;
    apos = 0;
    foreach (ent_valid[i]) begin
      ent_valid[i] = 0;
      ent_ans[i] = 0;
    end
    hold_go = 0;
    hold_done = 0;
    hold_left = 0;
    calm = 0;
    quiet_cnt = 0;
    clock_s = 1000;

    id_a_hi = '0;
    id_a_lo = '0;
    id_b_hi = '1;
    id_b_lo = '1;
    id_c_hi = 64'h0123_4567_89ab_cdef;
    id_c_lo = 64'hfedc_ba98_7654_3210;
    ids_hi[0] = id_a_hi;
    ids_lo[0] = id_a_lo;
    ids_hi[1] = id_b_hi;
    ids_lo[1] = id_b_lo;
    for (int i = 2; i < N_IDS; i++) begin
      ids_hi[i] = rnd64();
      ids_lo[i] = rnd64();
    end

    // directed stimulus
    dir_rows = '{
      '{ACT_LOOKUP, SH_NONE, id_a_hi, id_a_lo, 0, 1, 1, mk(KIND_LOOKUP, 0, 0)},
      '{ACT_REMOVE, SH_NONE, id_a_hi, id_a_lo, 0, 1, 1, mk(KIND_REMOVE, 0, 0)},
      '{ACT_PKT, SH_RUNT, 0, 0, 0, 1, 1, mk(KIND_VERDICT, VERDICT_RUNT, 0)},
      '{ACT_INSERT, SH_NONE, id_a_hi, id_a_lo, 100, 1, 1, mk(KIND_INSERT, 0, 1)},
      '{ACT_PKT, SH_REQ_PLAIN, id_b_hi, id_a_lo, 0, 1, 0, '0},
      '{ACT_PKT, SH_RESP_MAPPED, id_a_hi, id_a_lo, 0, 1, 0, '0},
      '{ACT_LOOKUP, SH_NONE, id_a_hi, id_a_lo, 0, 1, 0, '0},
      '{ACT_INSERT, SH_NONE, id_b_hi, id_b_lo, '1, 1, 1, mk(KIND_INSERT, 0, 1)},
      '{ACT_PKT, SH_RESP_SHORT, id_b_hi, id_b_lo, 0, 1, 0, '0},
      '{ACT_LOOKUP, SH_NONE, id_b_hi, id_b_lo, 0, 1, 0, '0},
      '{ACT_PKT, SH_REQ_USER, id_c_hi, id_c_lo, 0, 1, 0, '0},
      '{ACT_PKT, SH_REQ_EMPTY_USER, id_c_hi, id_c_lo, 0, 1, 0, '0},
      '{ACT_PKT, SH_BAD_VALUE, 0, 0, 0, 1, 1, mk(KIND_VERDICT, VERDICT_IGNORED, 0)},
      '{ACT_PKT, SH_RUNT_ATTR, 0, 0, 0, 1, 1, mk(KIND_VERDICT, VERDICT_IGNORED, 0)},
      '{ACT_PKT, SH_CLAMP, id_c_hi, id_c_lo, 0, 1, 0, '0},
      '{ACT_PKT, SH_CUTOFF, 0, 0, 0, 1, 1, mk(KIND_VERDICT, VERDICT_IGNORED, 0)},
      '{ACT_PKT, SH_TRAILING, id_b_hi, id_b_lo, 0, 1, 0, '0},
      '{ACT_PKT, SH_UNKNOWN, 0, 0, 0, 1, 1, mk(KIND_VERDICT, VERDICT_IGNORED, 0)},
      '{ACT_PKT, SH_OVERSIZE, id_c_hi, id_a_lo, 0, 1, 0, '0},
      '{ACT_CFG, SH_NONE, 0, 0, 0, 1, 0, '0},
      '{ACT_REMOVE, SH_NONE, id_a_hi, id_a_lo, 200, 1, 0, '0},
      '{ACT_INSERT, SH_NONE, id_c_hi, id_c_lo, 100, 7, 0, '0},
      '{ACT_INSERT, SH_NONE, id_c_hi, id_c_lo, 100, 1, 1, mk(KIND_INSERT, 0, 0)},
      '{ACT_PKT, SH_RESP_MAPPED, id_c_hi, id_c_lo, 0, 1, 0, '0},
      '{ACT_LOOKUP, SH_NONE, id_c_hi, id_c_lo, 0, 1, 0, '0},
      '{ACT_CFG, SH_NONE, 0, 0, 16'hffff, 1, 0, '0},
      '{ACT_REMOVE, SH_NONE, id_a_hi, id_a_lo, '1, 1, 0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      repeat (row.rep) begin
        case (row.act)
          ACT_PKT: begin
            build_shape(row.shape, row.hi, row.lo);
            send_packet(row.typed, row.want);
          end
          ACT_INSERT: send_table(FUNC_INSERT, row.hi, row.lo, row.now, row.typed, row.want);
          ACT_LOOKUP: send_table(FUNC_LOOKUP, row.hi, row.lo, row.now, row.typed, row.want);
          ACT_REMOVE: send_table(FUNC_REMOVE, row.hi, row.lo, row.now, row.typed, row.want);
          default: write_age_limit(16'(row.now));
        endcase
      end
    end
    write_age_limit(AGE_LIMIT_RESET);

    // random part: mostly well-formed traffic on a small id set
    base = items_in;
    cfg_mid = 0;
    hold_go = 1;
    build_random(1, rnd64(), rnd64());
    send_packet();
    while (items_in - base < 120) begin
      k = $urandom_range(N_IDS - 1);
      calm = (items_in - base >= 40) && (items_in - base < 80);
      clock_s += $urandom_range(0, 50);
      r = $urandom_range(99);
      if (r < 30) begin
        build_random(1, ids_hi[k], ids_lo[k]);
        send_packet();
      end else if (r < 55) begin
        build_random(0, ids_hi[k], ids_lo[k]);
        send_packet();
      end else if (r < 65) begin
        send_table(FUNC_INSERT, ids_hi[k], ids_lo[k], clock_s);
      end else if (r < 75) begin
        send_table(FUNC_LOOKUP, ids_hi[k], ids_lo[k], clock_s);
      end else if (r < 82) begin
        send_table(FUNC_REMOVE, ids_hi[k], ids_lo[k],
                   $urandom_range(9) == 0 ? $urandom : clock_s + $urandom_range(0, 700));
      end else if (r < 92) begin
        // broken packet: bad length, cut short, or one byte corrupted
        build_random($urandom_range(1), ids_hi[k], ids_lo[k]);
        case ($urandom_range(2))
          0: {pkt_bytes[2], pkt_bytes[3]} = 16'($urandom);
          1: pkt_bytes = pkt_bytes[0:$urandom_range(0, pkt_bytes.size() - 1)];
          default: pkt_bytes[$urandom_range(0, pkt_bytes.size() - 1)] = 8'($urandom);
        endcase
        send_packet();
      end else begin
        send_item(2'($urandom), 8'($urandom), 1'($urandom), $urandom, 16'($urandom),
                  $urandom_range(1) ? {ids_hi[k]} : rnd64(), ids_lo[k], $urandom);
      end
      if (!cfg_mid && items_in - base >= 60) begin
        cfg_mid = 1;
        write_age_limit(16'($urandom_range(0, 600)));
      end
    end
    calm = 0;
    in_valid_i <= 1'b0;

    // drain; the watchdog bounds this wait
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run: %0d input beats, %0d packets, %0d result beats checked",
             items_in, packets_sent, beats_out);
    $display("mismatches %0d, unexpected beats %0d, left over %0d",
             mismatches, strays, expected_beats.size());
    if (mismatches == 0 && strays == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/sbme_pkg.sv
design/sbme_front.sv
design/sbme_queue.sv
design/sbme_back.sv
design/stun_binding_message_engine.sv
sim/stun_binding_message_engine_test.sv
